@@ rtl/sms_pkg.sv @@
package sms_pkg;

  typedef enum logic [3:0] {
    PH_WAIT_CR  = 4'd0,
    PH_WAIT_LF  = 4'd1,
    PH_EXP_PLUS = 4'd2,
    PH_EXP_C    = 4'd3,
    PH_EXP_M    = 4'd4,
    PH_EXP_T    = 4'd5,
    PH_EXP_I    = 4'd6,
    PH_TO_COMMA = 4'd7,
    PH_INDEX    = 4'd8,
    PH_SKIP_LF  = 4'd9,
    PH_TEXT     = 4'd10
  } phase_t;

  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_COMMA = 8'h2c;

  localparam logic [3:0] CODE_FORWARD  = 4'h a;
  localparam logic [3:0] CODE_BACKWARD = 4'h5;
  localparam logic [3:0] CODE_LEFT     = 4'h2;
  localparam logic [3:0] CODE_RIGHT    = 4'h8;

  localparam int NUM_WORDS = 4;
  localparam int WORD_LEN  = 8;

  // burst slot positions within the 26-byte read request
  localparam logic [4:0] SLOT_INDEX = 5'd23;
  localparam logic [4:0] SLOT_CR    = 5'd24;
  localparam logic [4:0] SLOT_LAST  = 5'd25;

  localparam logic [1:0] SKIP_LAST = 2'd2;
  localparam logic [2:0] TEXT_LAST = 3'd7;

  function automatic logic [3:0] word_code(input logic [1:0] w);
    case (w)
      2'd0:    word_code = CODE_FORWARD;
      2'd1:    word_code = CODE_BACKWARD;
      2'd2:    word_code = CODE_LEFT;
      default: word_code = CODE_RIGHT;
    endcase
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] p);
    logic [8*WORD_LEN-1:0] s;
    case (w)
      2'd0:    s = "forward ";
      2'd1:    s = "backward";
      2'd2:    s = "left    ";
      default: s = "right   ";
    endcase
    word_char = s[8*(WORD_LEN-1-int'(p)) +: 8];
  endfunction

  function automatic logic [7:0] prefix_char(input phase_t ph);
    case (ph)
      PH_EXP_PLUS: prefix_char = "+";
      PH_EXP_C:    prefix_char = "C";
      PH_EXP_M:    prefix_char = "M";
      PH_EXP_T:    prefix_char = "T";
      default:     prefix_char = "I";
    endcase
  endfunction

  // fixed head of the read request: "at" CRLF "at+cmgf=1" CRLF "at+cmgr="
  function automatic logic [7:0] head_byte(input logic [4:0] k);
    case (k)
      5'd0:    head_byte = "a";
      5'd1:    head_byte = "t";
      5'd2:    head_byte = BYTE_CR;
      5'd3:    head_byte = BYTE_LF;
      5'd4:    head_byte = "a";
      5'd5:    head_byte = "t";
      5'd6:    head_byte = "+";
      5'd7:    head_byte = "c";
      5'd8:    head_byte = "m";
      5'd9:    head_byte = "g";
      5'd10:   head_byte = "f";
      5'd11:   head_byte = "=";
      5'd12:   head_byte = "1";
      5'd13:   head_byte = BYTE_CR;
      5'd14:   head_byte = BYTE_LF;
      5'd15:   head_byte = "a";
      5'd16:   head_byte = "t";
      5'd17:   head_byte = "+";
      5'd18:   head_byte = "c";
      5'd19:   head_byte = "m";
      5'd20:   head_byte = "g";
      5'd21:   head_byte = "r";
      5'd22:   head_byte = "=";
      default: head_byte = 8'h00;
    endcase
  endfunction

endpackage

@@ rtl/sms_command_word_decoder_unit.sv @@
// SMS command word decoder.
// Input channel: in_valid / in_stall carry rx_byte, one modem byte per
// transaction. Output channel: out_valid / out_stall carry tx_valid, tx_byte,
// drive, drive_changed and last, one result per transaction.
// Every received byte gives one result with tx_valid low, except the message
// index byte, which gives a burst of 26 results with tx_valid high (the read
// request for that message); last marks the final result of each byte.
// The first result of a byte is loaded into the output register as the byte
// is taken. Throughput: one byte per cycle while the receiver takes every
// result; an index byte holds the input until the burst counter has walked
// the request bytes out of the output register.
// A new byte is taken in the same cycle the last result of the previous byte
// leaves, so a receiver that never stalls sees no gap.
// When the receiver stalls, the output register holds its result and the
// input stalls as well. Reset (rst, synchronous) empties the output, returns
// parsing to waiting for CR and sets drive to zero.
module sms_command_word_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic [3:0] drive,
  output logic       drive_changed,
  output logic       last
);

  sms_pkg::phase_t phase, phase_next;
  logic [1:0] line_skip, line_skip_next;
  logic [2:0] text_pos, text_pos_next;
  logic [3:0] match_flags, match_flags_next;
  logic [3:0] drive_code, drive_code_next;
  logic       changed_next;
  logic       start_burst;

  logic       burst;
  logic [4:0] slot;
  logic [7:0] index_byte;
  logic       changed;

  logic       in_accept;
  logic       out_accept;
  logic       out_done;
  logic [3:0] flags_cmp;

  assign out_accept = out_valid && !out_stall;
  assign out_done   = out_accept && (!burst || slot == sms_pkg::SLOT_LAST);
  assign in_stall   = out_valid && !out_done;
  assign in_accept  = in_valid && !in_stall;

  always_comb begin
    phase_next       = phase;
    line_skip_next   = line_skip;
    text_pos_next    = text_pos;
    match_flags_next = match_flags;
    drive_code_next  = drive_code;
    changed_next     = 1'b0;
    start_burst      = 1'b0;
    for (int w = 0; w < sms_pkg::NUM_WORDS; w++) begin
      flags_cmp[w] = match_flags[w] && (rx_byte == sms_pkg::word_char(2'(w), text_pos));
    end
    case (phase)
      sms_pkg::PH_WAIT_CR: begin
        if (rx_byte == sms_pkg::BYTE_CR) phase_next = sms_pkg::PH_WAIT_LF;
      end
      sms_pkg::PH_WAIT_LF: begin
        if (rx_byte == sms_pkg::BYTE_LF) phase_next = sms_pkg::PH_EXP_PLUS;
      end
      sms_pkg::PH_EXP_PLUS, sms_pkg::PH_EXP_C, sms_pkg::PH_EXP_M,
      sms_pkg::PH_EXP_T, sms_pkg::PH_EXP_I: begin
        if (rx_byte == sms_pkg::prefix_char(phase)) begin
          phase_next = sms_pkg::phase_t'(phase + 4'd1);
        end else begin
          phase_next       = sms_pkg::PH_WAIT_CR;
          line_skip_next   = '0;
          text_pos_next    = '0;
          match_flags_next = '1;
        end
      end
      sms_pkg::PH_TO_COMMA: begin
        if (rx_byte == sms_pkg::BYTE_COMMA) phase_next = sms_pkg::PH_INDEX;
      end
      sms_pkg::PH_INDEX: begin
        phase_next     = sms_pkg::PH_SKIP_LF;
        line_skip_next = '0;
        start_burst    = 1'b1;
      end
      sms_pkg::PH_SKIP_LF: begin
        if (rx_byte == sms_pkg::BYTE_LF) begin
          if (line_skip >= sms_pkg::SKIP_LAST) begin
            phase_next       = sms_pkg::PH_TEXT;
            text_pos_next    = '0;
            match_flags_next = '1;
          end else begin
            line_skip_next = line_skip + 2'd1;
          end
        end
      end
      sms_pkg::PH_TEXT: begin
        match_flags_next = flags_cmp;
        if (text_pos == sms_pkg::TEXT_LAST) begin
          // later word wins if several matched
          for (int w = 0; w < sms_pkg::NUM_WORDS; w++) begin
            if (flags_cmp[w]) begin
              drive_code_next = sms_pkg::word_code(2'(w));
              changed_next    = 1'b1;
            end
          end
          phase_next       = sms_pkg::PH_WAIT_CR;
          line_skip_next   = '0;
          text_pos_next    = '0;
          match_flags_next = '1;
        end else begin
          text_pos_next = text_pos + 3'd1;
        end
      end
      default: begin
        phase_next       = sms_pkg::PH_WAIT_CR;
        line_skip_next   = '0;
        text_pos_next    = '0;
        match_flags_next = '1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sms_pkg::PH_WAIT_CR;
      line_skip   <= '0;
      text_pos    <= '0;
      match_flags <= '1;
      drive_code  <= '0;
    end else if (in_accept) begin
      phase       <= phase_next;
      line_skip   <= line_skip_next;
      text_pos    <= text_pos_next;
      match_flags <= match_flags_next;
      drive_code  <= drive_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      burst     <= 1'b0;
      slot      <= '0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
      burst     <= start_burst;
      slot      <= '0;
    end else if (out_done) begin
      out_valid <= 1'b0;
      burst     <= 1'b0;
    end else if (out_accept) begin
      // advance through the request bytes
      slot <= slot + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      index_byte <= rx_byte;
      changed    <= changed_next;
    end
  end

  always_comb begin
    tx_byte = 8'h00;
    if (burst) begin
      case (slot)
        sms_pkg::SLOT_INDEX: tx_byte = index_byte;
        sms_pkg::SLOT_CR:    tx_byte = sms_pkg::BYTE_CR;
        sms_pkg::SLOT_LAST:  tx_byte = sms_pkg::BYTE_LF;
        default:             tx_byte = sms_pkg::head_byte(slot);
      endcase
    end
  end

  assign tx_valid      = burst;
  assign drive         = drive_code;
  assign drive_changed = changed && !burst;
  assign last          = !burst || slot == sms_pkg::SLOT_LAST;

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && burst |-> slot <= sms_pkg::SLOT_LAST)
    else $error("burst slot beyond last request byte");

  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == sms_pkg::PH_INDEX |=> out_valid && burst && slot == 5'd0)
    else $error("index byte did not start a request burst");

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_changed |-> drive == sms_pkg::CODE_FORWARD ||
      drive == sms_pkg::CODE_BACKWARD || drive == sms_pkg::CODE_LEFT ||
      drive == sms_pkg::CODE_RIGHT)
    else $error("drive changed to an unknown code");

  a_text_end: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == sms_pkg::PH_TEXT && text_pos == sms_pkg::TEXT_LAST
      |=> phase == sms_pkg::PH_WAIT_CR && match_flags == 4'hf)
    else $error("message state not cleared after eighth text byte");

  a_drive_hold: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(drive))
    else $error("drive moved without a transaction");

endmodule
